@@ rtl/pacs_pkg.sv @@
// Shared types and constants for the paged Adler-32 image checksum block.
`timescale 1ns / 1ps
`default_nettype none

package pacs_pkg;

  // Adler-32 modulus, the largest prime below 2^16.
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Width and reset value of the page length register.
  localparam int PAGE_BYTES_W = 13;
  localparam logic [PAGE_BYTES_W-1:0] PAGE_BYTES_RESET = 13'd256;

  // Default upper bound on the page length.
  localparam int DEF_MAX_PAGE_BYTES = 4096;

  // Number of entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       close_page;
    logic       image_end;
  } pacs_item_t;

endpackage

`default_nettype wire

@@ rtl/pacs_front.sv @@
// Front end: accepts input words, counts bytes in the page and marks page closes.
`timescale 1ns / 1ps
`default_nettype none

module pacs_front
  import pacs_pkg::*;
#(
  parameter int MAX_PAGE_BYTES = DEF_MAX_PAGE_BYTES
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [PAGE_BYTES_W-1:0] page_bytes,
  input  wire logic                    in_valid,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    image_end,
  input  wire logic                    queue_full,
  output logic                         in_stall,
  output logic                         push,
  output pacs_item_t                   push_item
);

  localparam int CNT_W = $clog2(MAX_PAGE_BYTES + 1);
  localparam int LEN_W = (CNT_W > PAGE_BYTES_W) ? CNT_W : PAGE_BYTES_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAGE_BYTES);

  logic [CNT_W-1:0] bytes_in_page;
  logic [CNT_W-1:0] bytes_in_page_next;
  logic [LEN_W-1:0] cfg_len;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] count_inc;
  logic             close_page;

  // Clamp the programmed length into the supported range.
  always_comb begin
    cfg_len = LEN_W'(page_bytes);
    if (cfg_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = cfg_len;
    end
  end

  assign count_inc  = LEN_W'(bytes_in_page) + LEN_W'(1);
  assign close_page = (count_inc >= eff_len) || image_end;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_item.data_byte  = data_byte;
    push_item.close_page = close_page;
    push_item.image_end  = image_end;
  end

  assign bytes_in_page_next = close_page ? '0 : count_inc[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_page <= '0;
    end else if (push) begin
      bytes_in_page <= bytes_in_page_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pacs_queue.sv @@
// Short register queue between the front end and the checksum back end.
`timescale 1ns / 1ps
`default_nettype none

module pacs_queue
  import pacs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire pacs_item_t push_item,
  input  wire logic       pop,
  output logic            full,
  output logic            not_empty,
  output pacs_item_t      head_item
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  pacs_item_t       entries [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head_item = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + IDX_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pacs_back.sv @@
// Back end: updates the Adler-32 sums and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module pacs_back
  import pacs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire pacs_item_t item,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [31:0]     page_checksum,
  output logic [15:0]     page_number,
  output logic [31:0]     image_sum,
  output logic            image_done
);

  logic [15:0] sum_low;
  logic [15:0] sum_high;
  logic [15:0] pages_done;
  logic [31:0] running_image_sum;

  logic [16:0] low_add;
  logic [15:0] sum_low_next;
  logic [16:0] high_add;
  logic [15:0] sum_high_next;
  logic [31:0] checksum;
  logic [31:0] image_sum_next;
  logic        emit;

  // One conditional subtract per sum keeps each below the modulus.
  always_comb begin
    low_add = {1'b0, sum_low} + {9'd0, item.data_byte};
    if (low_add >= ADLER_MOD) begin
      low_add = low_add - ADLER_MOD;
    end
    sum_low_next = low_add[15:0];
    high_add = {1'b0, sum_high} + {1'b0, sum_low_next};
    if (high_add >= ADLER_MOD) begin
      high_add = high_add - ADLER_MOD;
    end
    sum_high_next = high_add[15:0];
  end

  assign checksum       = {sum_high_next, sum_low_next};
  assign image_sum_next = running_image_sum + checksum;

  assign pop  = item_valid && (!out_valid || !out_stall);
  assign emit = pop && item.close_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_low           <= 16'd1;
      sum_high          <= 16'd0;
      pages_done        <= '0;
      running_image_sum <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (item.close_page) begin
          sum_low   <= 16'd1;
          sum_high  <= 16'd0;
          out_valid <= 1'b1;
          if (item.image_end) begin
            pages_done        <= '0;
            running_image_sum <= '0;
          end else begin
            pages_done        <= pages_done + 16'd1;
            running_image_sum <= image_sum_next;
          end
        end else begin
          sum_low  <= sum_low_next;
          sum_high <= sum_high_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      page_checksum <= checksum;
      page_number   <= pages_done;
      image_sum     <= image_sum_next;
      image_done    <= item.image_end;
    end
  end

endmodule

`default_nettype wire

@@ rtl/paged_adler32_image_checksum.sv @@
// Top level of the paged Adler-32 image checksum block.
//
//   Channel  Direction  Handshake            Word contents
//   in       input      in_valid / in_stall  data_byte, image_end
//   out      output     out_valid/out_stall  page_checksum, page_number, image_sum, image_done
//   cfg      input      cfg_we               cfg_wdata (page length in bytes)
//
// The block takes one input word per cycle while the queue is not full. The front is
// combinational, so an accepted word is written into the queue at its accepting edge;
// the back end loads the result register when it pops the closing word from the queue,
// and folds one word per cycle into the sums while the output is not stalled.
// Reset is synchronous and clears the sums, the page and image state and the queue;
// the page length returns to 256 bytes.
// A stall on the output stops the back end only; the front keeps taking words
// until the two-entry queue fills, and then raises in_stall.
`timescale 1ns / 1ps
`default_nettype none

module paged_adler32_image_checksum
  import pacs_pkg::*;
#(
  parameter int MAX_PAGE_BYTES = DEF_MAX_PAGE_BYTES
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Page length register write port.
  input  wire logic                    cfg_we,
  input  wire logic [PAGE_BYTES_W-1:0] cfg_wdata,
  // Input words: one image byte each.
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    image_end,
  // Result words: one per closed page.
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [31:0]                  page_checksum,
  output logic [15:0]                  page_number,
  output logic [31:0]                  image_sum,
  output logic                         image_done
);

  // Page length as programmed. The front clamps it into 1..MAX_PAGE_BYTES
  // when it decides where a page ends.
  logic [PAGE_BYTES_W-1:0] page_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= PAGE_BYTES_RESET;
    end else if (cfg_we) begin
      page_bytes <= cfg_wdata;
    end
  end

  logic       queue_full;
  logic       queue_not_empty;
  logic       push;
  logic       pop;
  pacs_item_t push_item;
  pacs_item_t head_item;

  // The front only counts bytes, so it can decide page closes without
  // waiting for the sums.
  pacs_front #(
    .MAX_PAGE_BYTES(MAX_PAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .page_bytes(page_bytes),
    .in_valid  (in_valid),
    .data_byte (data_byte),
    .image_end (image_end),
    .queue_full(queue_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_item (push_item)
  );

  pacs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .full     (queue_full),
    .not_empty(queue_not_empty),
    .head_item(head_item)
  );

  // The back folds each byte into the sums and loads the result register
  // when a word closes a page.
  pacs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (queue_not_empty),
    .item         (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .page_checksum(page_checksum),
    .page_number  (page_number),
    .image_sum    (image_sum),
    .image_done   (image_done)
  );

endmodule

`default_nettype wire

@@ rtl/pacs_checker.sv @@
// Port-level checks of the checksum block and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pacs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] page_checksum,
  input wire logic [15:0] page_number,
  input wire logic [31:0] image_sum,
  input wire logic        image_done
);

  logic        have_prev;
  logic        prev_done;
  logic [15:0] prev_number;
  logic [31:0] prev_sum;
  logic        out_take;

  assign out_take = out_valid && !out_stall;

  // Remember the last result word that was taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev   <= 1'b0;
      prev_done   <= 1'b0;
      prev_number <= '0;
      prev_sum    <= '0;
    end else if (out_take) begin
      have_prev   <= 1'b1;
      prev_done   <= image_done;
      prev_number <= page_number;
      prev_sum    <= image_sum;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid)
    else $error("stalled result word dropped");

  a_page_seq: assert property (@(posedge clk) disable iff (rst)
      out_valid && have_prev |->
        page_number == (prev_done ? 16'd0 : prev_number + 16'd1))
    else $error("page number out of sequence");

  a_sum_seq: assert property (@(posedge clk) disable iff (rst)
      out_valid && have_prev |->
        image_sum == ((prev_done ? 32'd0 : prev_sum) + page_checksum))
    else $error("image sum does not follow page checksums");

endmodule

bind paged_adler32_image_checksum pacs_checker u_pacs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .page_checksum(page_checksum),
  .page_number  (page_number),
  .image_sum    (image_sum),
  .image_done   (image_done)
);

`default_nettype wire

@@ tb/sv/tb_paged_adler32_image_checksum.sv @@
// Self-checking testbench for the paged Adler-32 image checksum block.
`timescale 1ns / 1ps

module tb_paged_adler32_image_checksum;
  import pacs_pkg::*;

  localparam int RANDOM_ITEMS     = 985;
  localparam int TAIL_ITEMS       = 150;   // final random words run with no idling
  localparam int LONG_HOLD_CYCLES = 48;
  localparam int HOLD_WORDS       = 40;
  localparam int IDLE_CYCLES      = 8;     // quiet output cycles required before the block counts as idle
  localparam int DRAIN_LIMIT      = 200000;
  localparam int DIR_ROWS         = 23;

  // One result word as the block presents it.
  typedef struct packed {
    logic [31:0] page_checksum;
    logic [15:0] page_number;
    logic [31:0] image_sum;
    logic        image_done;
  } page_result_t;

  // One row of the directed table. A row may first rewrite the page length, which
  // happens only once the block has gone quiet. Where typed is set, the expected
  // result is the literal on the row rather than the predictor's.
  typedef struct packed {
    logic                    set_len;
    logic [PAGE_BYTES_W-1:0] len;
    logic [7:0]              data;
    logic                    last;
    logic                    typed;
    logic [31:0]             chk;
    logic [15:0]             num;
    logic [31:0]             isum;
    logic                    done;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    // Straight after reset: single-byte images, extremes of the data byte.
    '{1'b0, 13'd0,    8'h00, 1'b1, 1'b1, 32'h00010001, 16'd0, 32'h00010001, 1'b1},
    '{1'b0, 13'd0,    8'hFF, 1'b1, 1'b1, 32'h01000100, 16'd0, 32'h01000100, 1'b1},
    // Partial page at the reset length, then length zero (acts as one) mid page.
    '{1'b0, 13'd0,    8'h12, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b1, 13'd0,    8'h34, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'hFF, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'h00, 1'b1, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    // Shortest legal page: every byte closes a page.
    '{1'b1, 13'd1,    8'h01, 1'b0, 1'b1, 32'h00020002, 16'd0, 32'h00020002, 1'b0},
    '{1'b0, 13'd0,    8'h01, 1'b0, 1'b1, 32'h00020002, 16'd1, 32'h00040004, 1'b0},
    '{1'b0, 13'd0,    8'hFF, 1'b1, 1'b1, 32'h01000100, 16'd2, 32'h01040104, 1'b1},
    // All-ones length is clamped to the maximum; a short last page closes at image end.
    '{1'b1, 13'd8191, 8'hFF, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'hFF, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'h00, 1'b1, 1'b1, 32'h04FE01FF, 16'd0, 32'h04FE01FF, 1'b1},
    // Length shrinks from three to two after two bytes: the next byte closes the page.
    '{1'b1, 13'd3,    8'h10, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'h20, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b1, 13'd2,    8'h30, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'h40, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'h50, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    // Largest legal length, closed early by image end.
    '{1'b1, 13'd4096, 8'h00, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'hFF, 1'b1, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    // One above the maximum is clamped as well.
    '{1'b1, 13'd4097, 8'h80, 1'b1, 1'b1, 32'h00810081, 16'd0, 32'h00810081, 1'b1},
    // Two-byte pages ending in a single-byte last page.
    '{1'b1, 13'd2,    8'hFF, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'hFF, 1'b0, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0},
    '{1'b0, 13'd0,    8'hFF, 1'b1, 1'b0, 32'h0,        16'd0, 32'h0,        1'b0}
  };

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [PAGE_BYTES_W-1:0] cfg_wdata = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic [7:0]              data_byte = '0;
  logic                    image_end = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [31:0]             page_checksum;
  logic [15:0]             page_number;
  logic [31:0]             image_sum;
  logic                    image_done;

  // Expected page results, oldest first.
  page_result_t pending_pages[$];

  // Predictor state: the block's page and image state plus its length register.
  logic [15:0]             mdl_sum_a;
  logic [15:0]             mdl_sum_b;
  logic [13:0]             mdl_fill;
  logic [15:0]             mdl_page_idx;
  logic [31:0]             mdl_image_sum;
  logic [PAGE_BYTES_W-1:0] mdl_page_len;

  bit src_idle_on   = 1'b1;
  bit sink_idle_on  = 1'b1;
  bit hold_request  = 1'b0;
  int fail_count    = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int len_settings  = 0;

  paged_adler32_image_checksum uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .image_end    (image_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .page_checksum(page_checksum),
    .page_number  (page_number),
    .image_sum    (image_sum),
    .image_done   (image_done)
  );

  always #6 clk = ~clk;

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #120_000_000;
    $display("paged_adler32_image_checksum verification failed");
    $finish;
  end

  // The page length the block actually uses: zero acts as one, and anything
  // above the maximum acts as the maximum.
  function automatic logic [13:0] page_limit(input logic [PAGE_BYTES_W-1:0] len);
    if (len == '0) begin
      return 14'd1;
    end
    if (len > DEF_MAX_PAGE_BYTES) begin
      return 14'(DEF_MAX_PAGE_BYTES);
    end
    return 14'(len);
  endfunction

  // Folds one image byte into the page sums; returns 1 and the result word
  // when the byte closes a page.
  function automatic bit predict_page_close(input logic [7:0] b, input logic last,
                                            output page_result_t res);
    logic [16:0] a_next;
    logic [16:0] b_next;
    logic [31:0] chk;
    a_next = {1'b0, mdl_sum_a} + {9'd0, b};
    if (a_next >= ADLER_MOD) begin
      a_next = a_next - ADLER_MOD;
    end
    b_next = {1'b0, mdl_sum_b} + a_next;
    if (b_next >= ADLER_MOD) begin
      b_next = b_next - ADLER_MOD;
    end
    mdl_sum_a = a_next[15:0];
    mdl_sum_b = b_next[15:0];
    mdl_fill  = mdl_fill + 14'd1;
    res = '0;
    if (mdl_fill < page_limit(mdl_page_len) && !last) begin
      return 1'b0;
    end
    chk = {mdl_sum_b, mdl_sum_a};
    res.page_checksum = chk;
    res.page_number   = mdl_page_idx;
    res.image_sum     = mdl_image_sum + chk;
    res.image_done    = last;
    mdl_sum_a = 16'd1;
    mdl_sum_b = 16'd0;
    mdl_fill  = '0;
    if (last) begin
      mdl_page_idx  = '0;
      mdl_image_sum = '0;
    end else begin
      mdl_page_idx  = mdl_page_idx + 16'd1;
      mdl_image_sum = res.image_sum;
    end
    return 1'b1;
  endfunction

  // Data bytes lean toward all ones so that the high sum and the image sum wrap often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0, 1: return 8'hFF;
      2: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid is left
  // high so that a following word goes out back to back.
  task automatic send_word(input logic [7:0] b, input logic last, input bit typed,
                           input page_result_t want);
    page_result_t res;
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    image_end <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (predict_page_close(b, last, res)) begin
      pending_pages.push_back(typed ? want : res);
    end else if (typed) begin
      pending_pages.push_back(want);
    end
  endtask

  // Waits until every expected result has come and the output side has stayed free through
  // an unbroken quiet run, so that words that close no page have left the pipeline too.
  task automatic wait_block_idle();
    int quiet;
    quiet = 0;
    in_valid <= 1'b0;
    while (quiet < IDLE_CYCLES) begin
      @(posedge clk);
      if (pending_pages.size() == 0 && !out_stall) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
  endtask

  task automatic write_page_len(input logic [PAGE_BYTES_W-1:0] len);
    wait_block_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_page_len = len;
    len_settings++;
  endtask

  // Output side: random stall bursts, plus one long hold-off on request so the
  // queue fills and the block stalls its input.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every result word taken is matched against the oldest expectation.
  always @(posedge clk) begin
    page_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_pages.size() == 0) begin
        $error("result word with no page expected: checksum %h page %0d", page_checksum,
               page_number);
        fail_count++;
      end else begin
        exp_res = pending_pages.pop_front();
        if (page_checksum !== exp_res.page_checksum) begin
          $error("page_checksum expected %h actual %h", exp_res.page_checksum, page_checksum);
          fail_count++;
        end
        if (page_number !== exp_res.page_number) begin
          $error("page_number expected %0d actual %0d", exp_res.page_number, page_number);
          fail_count++;
        end
        if (image_sum !== exp_res.image_sum) begin
          $error("image_sum expected %h actual %h", exp_res.image_sum, image_sum);
          fail_count++;
        end
        if (image_done !== exp_res.image_done) begin
          $error("image_done expected %b actual %b", exp_res.image_done, image_done);
          fail_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t     row;
    page_result_t want;
    logic [PAGE_BYTES_W-1:0] len;
    int rand_sent;
    int n_img;
    int span;
    int img_len;
    bit broken;
    int guard;

    mdl_sum_a     = 16'd1;
    mdl_sum_b     = 16'd0;
    mdl_fill      = '0;
    mdl_page_idx  = '0;
    mdl_image_sum = '0;
    mdl_page_len  = PAGE_BYTES_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.set_len) begin
        write_page_len(row.len);
      end
      want = '{row.chk, row.num, row.isum, row.done};
      send_word(row.data, row.last, row.typed, want);
    end

    // Long hold-off on the output while single-byte pages keep arriving back to back.
    write_page_len(13'd1);
    src_idle_on  = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < HOLD_WORDS; i++) begin
      send_word(pick_byte(), i == HOLD_WORDS - 1, 1'b0, '0);
    end
    src_idle_on = 1'b1;

    // Random images under random page lengths, mostly short; now and then an image
    // is cut off without its end marker and the length changes under a partial page.
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: len = '0;
        1: len = PAGE_BYTES_W'($urandom_range(DEF_MAX_PAGE_BYTES + 1, 8191));
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11: len = PAGE_BYTES_W'($urandom_range(1, 16));
        12, 13, 14, 15, 16, 17: len = PAGE_BYTES_W'($urandom_range(17, 64));
        default: len = PAGE_BYTES_W'($urandom_range(65, 300));
      endcase
      write_page_len(len);
      n_img = $urandom_range(1, 3);
      for (int k = 0; k < n_img; k++) begin
        span = 4 * int'(page_limit(len));
        if (span > 300) begin
          span = 300;
        end
        img_len = $urandom_range(1, span);
        if (img_len > RANDOM_ITEMS - rand_sent) begin
          img_len = RANDOM_ITEMS - rand_sent;
        end
        broken  = ($urandom_range(0, 9) == 0);
        if (rand_sent >= RANDOM_ITEMS - TAIL_ITEMS) begin
          src_idle_on  = 1'b0;
          sink_idle_on = 1'b0;
        end
        for (int j = 0; j < img_len; j++) begin
          send_word(pick_byte(), !broken && j == img_len - 1, 1'b0, '0);
          rand_sent++;
        end
      end
    end

    // Let the last results drain, then wait on for strays.
    in_valid <= 1'b0;
    guard = 0;
    while (pending_pages.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_pages.size() != 0) begin
      $display("timed out with %0d page results outstanding", pending_pages.size());
      $display("paged_adler32_image_checksum verification failed");
      $finish;
    end else begin
      repeat (4 * IDLE_CYCLES) @(posedge clk);
      $display("Run covered %0d words and %0d page results under %0d page lengths,",
               words_sent, results_seen, len_settings);
      $display("including zero, one, 4096 and clamped lengths and a long output hold-off.");
      if (fail_count == 0) begin
        $display("paged_adler32_image_checksum verification clean");
      end else begin
        $display("paged_adler32_image_checksum verification failed");
      end
      $finish;
    end
  end

endmodule
